### hw/rtl/dfq_pkg.sv
// ----------------------------------------------------------------------------
// dfq_pkg
// Shared widths, status and op codes, and the cell control struct for the
// duplicate-rejecting fifo queue.
// ----------------------------------------------------------------------------
package dfq_pkg;

  localparam int VAL_W    = 32;
  localparam int CNT_W    = 8;
  localparam int ST_W     = 3;
  // match bits or-ed together per group in the first tree level
  localparam int GRP_SIZE = 16;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [ST_W-1:0] ST_ENQ   = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP   = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_DEQ   = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd4;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic load;   // write the pending value into the cell at the fill index
    logic shift;  // every cell takes its right neighbor's value
  } cell_ctl_t;

endpackage

### hw/rtl/dfq_in_if.sv
// ----------------------------------------------------------------------------
// dfq_in_if
// Request channel: op and value under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dfq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [dfq_pkg::VAL_W-1:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

### hw/rtl/dfq_out_if.sv
// ----------------------------------------------------------------------------
// dfq_out_if
// Result channel: status, removed value and new count under valid/ready.
// ----------------------------------------------------------------------------
interface dfq_out_if;
  logic                              valid;
  logic                              ready;
  logic        [dfq_pkg::ST_W-1:0]   status;
  logic signed [dfq_pkg::VAL_W-1:0]  removed;
  logic        [dfq_pkg::CNT_W-1:0]  count;

  modport source (output valid, output status, output removed, output count,
                  input ready);
  modport sink   (input valid, input status, input removed, input count,
                  output ready);
endinterface

### hw/rtl/dfq_cell.sv
// ----------------------------------------------------------------------------
// dfq_cell
// One queue slot: holds a value, takes its neighbor's on a shift, and
// registers whether it holds the probe value while it is occupied.
// ----------------------------------------------------------------------------
module dfq_cell #(
  parameter int IDX = 0,
  parameter int FW  = 8
) (
  input  logic                              clk,
  input  dfq_pkg::cell_ctl_t                ctl,
  input  logic [FW-1:0]                     fill,
  input  logic signed [dfq_pkg::VAL_W-1:0]  cmp_val,
  input  logic signed [dfq_pkg::VAL_W-1:0]  nxt_val,
  output logic signed [dfq_pkg::VAL_W-1:0]  val,
  output logic                              match
);

  localparam logic [FW-1:0] MY_IDX = FW'(IDX);

  logic signed [dfq_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                             match_r, match_nxt;

  always_comb begin
    priority if (ctl.load && (fill == MY_IDX)) begin
      val_nxt = cmp_val;
    end else if (ctl.shift) begin
      val_nxt = nxt_val;
    end else begin
      val_nxt = val_r;
    end
  end

  // only slots below the fill count take part in the search
  assign match_nxt = (val_r == cmp_val) && (fill > MY_IDX);

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    match_r <= match_nxt;
  end

  assign val   = val_r;
  assign match = match_r;

endmodule

### hw/rtl/dfq_match_tree.sv
// ----------------------------------------------------------------------------
// dfq_match_tree
// First level of the hit reduction: or of each group of match bits,
// registered.
// ----------------------------------------------------------------------------
module dfq_match_tree #(
  parameter int N  = 128,
  parameter int NG = 8
) (
  input  logic           clk,
  input  logic [N-1:0]   bits,
  output logic [NG-1:0]  grp
);

  logic [NG-1:0] grp_r, grp_nxt;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = 1'b0;
      for (int k = 0; k < dfq_pkg::GRP_SIZE; k++) begin
        if (g * dfq_pkg::GRP_SIZE + k < N) begin
          grp_nxt[g] = grp_nxt[g] | bits[g * dfq_pkg::GRP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  assign grp = grp_r;

endmodule

### hw/rtl/dedup_fifo_queue.sv
// ----------------------------------------------------------------------------
// dedup_fifo_queue
// Fifo queue of distinct signed values built as a chain of cells; enqueue
// refuses duplicates and a full queue, dequeue returns the front value.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  -------------------------------------------
//  in_ch    in   valid / ready  op (1), value (32 signed)
//  out_ch   out  valid / ready  status (3), removed (32 signed), count (8)
//
//  each item goes through accept, compare in every cell, group or of
//  the match bits, then commit and load the output register
//  the commit waits while a previous result still sits in the output
//  register and is not taken; a new item is accepted while a result waits
//  reset clears the fill count and the control; slot contents are not cleared
//  only slots below the fill count are ever searched or returned
//
module dedup_fifo_queue #(
  parameter int DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  dfq_in_if.sink        in_ch,
  dfq_out_if.source     out_ch
);

  localparam int FW = $clog2(DEPTH + 1);
  localparam int NG = (DEPTH + dfq_pkg::GRP_SIZE - 1) / dfq_pkg::GRP_SIZE;
  localparam logic [FW-1:0] FULL_CNT = FW'(DEPTH);

  // one-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_RED  = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // request held for the duration of the item
  logic                             op_r;
  logic signed [dfq_pkg::VAL_W-1:0] value_r;

  // occupancy
  logic [FW-1:0] fill_r, fill_nxt;

  // chain wiring
  logic [DEPTH-1:0][dfq_pkg::VAL_W-1:0] cell_val;
  logic [DEPTH-1:0]                     cell_match;
  logic [NG-1:0]                        grp_hit;
  dfq_pkg::cell_ctl_t                   ctl;

  // commit decision
  logic                             fire;
  logic                             hit;
  logic [dfq_pkg::ST_W-1:0]         status_c;
  logic signed [dfq_pkg::VAL_W-1:0] removed_c;

  // output register
  logic                             out_vld_r;
  logic [dfq_pkg::ST_W-1:0]         status_r;
  logic signed [dfq_pkg::VAL_W-1:0] removed_r;
  logic [dfq_pkg::CNT_W-1:0]        count_r;

  // ------------------------------------------------------------------
  // cell chain: slot 0 is the front, a shift moves everything forward
  // ------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [dfq_pkg::VAL_W-1:0] nxt_v;
    if (i < DEPTH - 1) begin : g_mid
      assign nxt_v = cell_val[i+1];
    end else begin : g_last
      // last slot keeps its value; it is beyond the fill after a shift
      assign nxt_v = cell_val[i];
    end

    dfq_cell #(
      .IDX (i),
      .FW  (FW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .fill    (fill_r),
      .cmp_val (value_r),
      .nxt_val (nxt_v),
      .val     (cell_val[i]),
      .match   (cell_match[i])
    );
  end

  // group or of match bits, registered
  dfq_match_tree #(
    .N  (DEPTH),
    .NG (NG)
  ) u_tree (
    .clk  (clk),
    .bits (cell_match),
    .grp  (grp_hit)
  );

  assign hit = |grp_hit;

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  // no request is taken while reset is held
  assign in_ch.ready = rst_n && (state_r == S_IDLE);

  // commit only when the output register is free or being emptied
  assign fire = (state_r == S_EXEC) && (!out_vld_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) begin
        state_nxt = S_CMP;
      end
      S_CMP:  state_nxt = S_RED;
      S_RED:  state_nxt = S_EXEC;
      S_EXEC: if (fire) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r    <= in_ch.op;
      value_r <= in_ch.value;
    end
  end

  // ------------------------------------------------------------------
  // commit: duplicate check wins over full
  // ------------------------------------------------------------------
  always_comb begin
    ctl       = '0;
    fill_nxt  = fill_r;
    status_c  = dfq_pkg::ST_ENQ;
    removed_c = '0;
    if (op_r == dfq_pkg::OP_ENQ) begin
      priority if (hit) begin
        status_c = dfq_pkg::ST_DUP;
      end else if (fill_r == FULL_CNT) begin
        status_c = dfq_pkg::ST_FULL;
      end else begin
        status_c = dfq_pkg::ST_ENQ;
        ctl.load = fire;
        fill_nxt = fill_r + FW'(1);
      end
    end else begin
      priority if (fill_r == '0) begin
        status_c = dfq_pkg::ST_EMPTY;
      end else begin
        status_c  = dfq_pkg::ST_DEQ;
        removed_c = cell_val[0];
        ctl.shift = fire;
        fill_nxt  = fill_r - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (fire) begin
      fill_r <= fill_nxt;
    end
  end

  // ------------------------------------------------------------------
  // output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r  <= status_c;
      removed_r <= removed_c;
      count_r   <= dfq_pkg::CNT_W'(fill_nxt);
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.status  = status_r;
  assign out_ch.removed = removed_r;
  assign out_ch.count   = count_r;

endmodule

### hw/rtl/dfq_checker.sv
// ----------------------------------------------------------------------------
// dfq_checker
// Port-level checks on the duplicate-rejecting fifo queue, bound to the
// top level.
// ----------------------------------------------------------------------------
module dfq_checker #(
  parameter int DEPTH = 128
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [dfq_pkg::ST_W-1:0]          out_status,
  input logic signed [dfq_pkg::VAL_W-1:0]  out_removed,
  input logic [dfq_pkg::CNT_W-1:0]         out_count
);

  // count field of a full queue
  localparam logic [dfq_pkg::CNT_W-1:0] FULL_COUNT = DEPTH[dfq_pkg::CNT_W-1:0];

  // a result stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // one item in flight: no request taken right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while one is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == dfq_pkg::ST_ENQ || out_status == dfq_pkg::ST_DUP ||
                   out_status == dfq_pkg::ST_FULL || out_status == dfq_pkg::ST_DEQ ||
                   out_status == dfq_pkg::ST_EMPTY))
    else $error("undefined status code");

  // removed is only nonzero on a dequeue
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dfq_pkg::ST_DEQ |-> out_removed == '0)
    else $error("removed value on a non-dequeue result");

  // empty shows zero, a full refusal shows the capacity
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dfq_pkg::ST_EMPTY || out_status == dfq_pkg::ST_FULL) |->
      out_count == ((out_status == dfq_pkg::ST_FULL) ? FULL_COUNT : '0))
    else $error("empty or full result with wrong count");

endmodule

bind dedup_fifo_queue dfq_checker #(
  .DEPTH (DEPTH)
) u_dfq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_removed (out_ch.removed),
  .out_count   (out_ch.count)
);

### test/tb_dedup_fifo_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dedup_fifo_queue
// Self-checking bench for the duplicate-rejecting fifo queue. A clocked
// driver feeds requests from a backlog, and a software queue of held values
// predicts status, removed value and count for every accepted item. A clocked
// monitor compares each result with the oldest prediction. Random gaps, idle
// and burst stretches, and one long receiver hold-off stall both sides.
// ----------------------------------------------------------------------------
module tb_dedup_fifo_queue;

  localparam int QDEPTH     = 128;
  localparam int CYCLE_CAP  = 300000;
  localparam int DRAIN_WAIT = 8;      // margin beyond the accept, compare, reduce and commit steps
  localparam int HOLD_LEN   = 300;    // long receiver hold-off, in cycles
  localparam int HOLD_AT    = 330;    // accepted items before the hold-off starts

  typedef struct packed {
    logic                             op;
    logic signed [dfq_pkg::VAL_W-1:0] value;
  } q_req_t;

  typedef struct packed {
    logic        [dfq_pkg::ST_W-1:0]  status;
    logic signed [dfq_pkg::VAL_W-1:0] removed;
    logic        [dfq_pkg::CNT_W-1:0] count;
  } q_res_t;

  logic clk;
  logic rst_n;

  dfq_in_if  in_if ();
  dfq_out_if out_if ();

  dedup_fifo_queue #(
    .DEPTH (QDEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // stimulus backlog and the predicted results, oldest first
  q_req_t                           req_backlog[$];
  q_res_t                           pending_results[$];
  // values held by the predicted queue, front at index 0
  logic signed [dfq_pkg::VAL_W-1:0] held_vals[$];
  // values recently offered for enqueue, source of duplicates
  logic signed [dfq_pkg::VAL_W-1:0] recent_enq[$];

  logic signed [dfq_pkg::VAL_W-1:0] corner_vals[5] = '{32'sh8000_0000, 32'sh7fff_ffff,
                                                       32'sh0, -32'sd1, 32'sd1};

  int  err_cnt      = 0;
  int  cycle_cnt    = 0;
  int  accepted_cnt = 0;
  bit  in_taken     = 1'b0;
  int  in_gap       = 0;
  bit  in_burst     = 1'b0;
  int  out_stall    = 0;
  bit  out_burst    = 1'b0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: one request in, one result out, held values updated in place
  // ---------------------------------------------------------------------------
  function automatic q_res_t apply_request(input q_req_t rq);
    q_res_t res;
    bit     hit;
    res.removed = '0;
    hit = 1'b0;
    if (rq.op == dfq_pkg::OP_ENQ) begin
      foreach (held_vals[i]) begin
        if (held_vals[i] == rq.value) hit = 1'b1;
      end
      // the duplicate check wins over the full check
      if (hit) begin
        res.status = dfq_pkg::ST_DUP;
      end else if (held_vals.size() >= QDEPTH) begin
        res.status = dfq_pkg::ST_FULL;
      end else begin
        held_vals.push_back(rq.value);
        res.status = dfq_pkg::ST_ENQ;
      end
    end else begin
      if (held_vals.size() == 0) begin
        res.status = dfq_pkg::ST_EMPTY;
      end else begin
        res.removed = held_vals.pop_front();
        res.status  = dfq_pkg::ST_DEQ;
      end
    end
    res.count = dfq_pkg::CNT_W'(held_vals.size());
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(input logic op, input logic signed [dfq_pkg::VAL_W-1:0] value);
    q_req_t rq;
    rq.op    = op;
    rq.value = value;
    req_backlog.push_back(rq);
    if (op == dfq_pkg::OP_ENQ) begin
      recent_enq.push_back(value);
      if (recent_enq.size() > 160) void'(recent_enq.pop_front());
    end
  endtask

  // dup_pct: chance of reusing a recent value, which is likely still held
  function automatic logic signed [dfq_pkg::VAL_W-1:0] pick_value(input int dup_pct);
    int r;
    r = $urandom_range(99);
    if (r < dup_pct && recent_enq.size() > 0)
      return recent_enq[$urandom_range(recent_enq.size() - 1)];
    if (r < dup_pct + 5)
      return corner_vals[$urandom_range(4)];
    return $urandom;
  endfunction

  task automatic run_phase(input int n_items, input int enq_pct, input int dup_pct);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < enq_pct)
        add_item(dfq_pkg::OP_ENQ, pick_value(dup_pct));
      else
        add_item(dfq_pkg::OP_DEQ, $urandom);  // value is don't-care on dequeue
    end
  endtask

  // mostly short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // input side: acceptance and prediction at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    q_req_t rq;
    cycle_cnt = cycle_cnt + 1;
    in_taken  = rst_n && in_if.valid && in_if.ready;
    if (in_taken) begin
      rq.op    = in_if.op;
      rq.value = in_if.value;
      pending_results.push_back(apply_request(rq));
      accepted_cnt = accepted_cnt + 1;
    end
  end

  // driver: holds the item until it is taken, then waits out a gap
  always @(negedge clk) begin
    q_req_t rq;
    if (rst_n && (!in_if.valid || in_taken)) begin
      if ($urandom_range(39) == 0) in_burst = !in_burst;
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_if.valid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        rq = req_backlog.pop_front();
        in_if.valid <= 1'b1;
        in_if.op    <= rq.op;
        in_if.value <= rq.value;
        in_gap = in_burst ? 0 : draw_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output side: receiver stalls and the long hold-off
  // ---------------------------------------------------------------------------
  // once, mid-run, stop taking results so the queue backs up to the input
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && accepted_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end else if (hold_left > 0) begin
        hold_left = hold_left - 1;
      end
    end
  end

  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if ($urandom_range(39) == 0) out_burst = !out_burst;
      if (hold_left > 0) begin
        rdy = 1'b0;
      end else if (out_stall > 0) begin
        out_stall = out_stall - 1;
      end else begin
        rdy = 1'b1;
        if (!out_burst && $urandom_range(99) < 20) out_stall = draw_gap();
      end
    end
    out_if.ready <= rdy;
  end

  // monitor: every taken result against the oldest prediction
  always @(posedge clk) begin
    q_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing predicted, status %0d removed %0d count %0d",
                 $time, out_if.status, out_if.removed, out_if.count);
        err_cnt = err_cnt + 1;
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_if.status);
          err_cnt = err_cnt + 1;
        end
        if (out_if.removed !== want.removed) begin
          $display("%0t: removed mismatch, expected %0d, actual %0d",
                   $time, want.removed, out_if.removed);
          err_cnt = err_cnt + 1;
        end
        if (out_if.count !== want.count) begin
          $display("%0t: count mismatch, expected %0d, actual %0d",
                   $time, want.count, out_if.count);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: build the backlog, reset, then wait for the queue to drain
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.op     = dfq_pkg::OP_ENQ;
    in_if.value  = '0;
    out_if.ready = 1'b0;

    // directed: corners, duplicates at the front and deeper in, empty dequeues
    add_item(dfq_pkg::OP_DEQ, 32'sh0);            // dequeue on empty
    add_item(dfq_pkg::OP_ENQ, 32'sh8000_0000);
    add_item(dfq_pkg::OP_ENQ, 32'sh7fff_ffff);
    add_item(dfq_pkg::OP_ENQ, 32'sh0);
    add_item(dfq_pkg::OP_ENQ, -32'sd1);
    add_item(dfq_pkg::OP_ENQ, 32'sd1);
    add_item(dfq_pkg::OP_ENQ, 32'sh8000_0000);    // duplicate of the front entry
    add_item(dfq_pkg::OP_ENQ, -32'sd1);           // duplicate deeper in
    add_item(dfq_pkg::OP_DEQ, 32'sh0);
    add_item(dfq_pkg::OP_ENQ, 32'sh8000_0000);    // no longer held, accepted again
    add_item(dfq_pkg::OP_ENQ, 32'shaaaa_aaaa);
    add_item(dfq_pkg::OP_ENQ, 32'sh5555_5555);
    repeat (7) add_item(dfq_pkg::OP_DEQ, 32'shffff_ffff);
    add_item(dfq_pkg::OP_DEQ, 32'sh1234_5678);    // empty again, value ignored
    add_item(dfq_pkg::OP_ENQ, 32'sd5);
    add_item(dfq_pkg::OP_DEQ, 32'sd5);            // value on a dequeue has no effect
    add_item(dfq_pkg::OP_ENQ, 32'sd5);

    // random: fill up to full, churn while full, drain, then mixed traffic
    run_phase(190, 97, 10);
    run_phase(150, 60, 35);
    run_phase(170,  8, 20);
    run_phase(190, 55, 25);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (!(req_backlog.size() == 0 && !in_if.valid && pending_results.size() == 0))
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/dfq_pkg.sv
hw/rtl/dfq_in_if.sv
hw/rtl/dfq_out_if.sv
hw/rtl/dfq_cell.sv
hw/rtl/dfq_match_tree.sv
hw/rtl/dedup_fifo_queue.sv
hw/rtl/dfq_checker.sv
test/tb_dedup_fifo_queue.sv
